>>> rtl/core/assert_macros.svh
// assertion macros shared by the sleep timer table rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define STT_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sleep timer table check failed");

// next-cycle implication, disabled during reset
`define STT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sleep timer table check failed");

`endif

>>> rtl/core/stt_pkg.sv
// sleep timer table package: field widths, microcode types and program rom
`default_nettype none

package stt_pkg;

    localparam int DUR_W  = 32;
    localparam int TASK_W = 16;
    localparam int UP_W   = 64;
    localparam int STEP_W = 4;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_ELAPSE = 1'b1;

    localparam logic [DUR_W-1:0] CAP_RESET = 32'd5;

    typedef logic [STEP_W-1:0] step_t;

    // program addresses
    localparam step_t S_IDLE    = 4'd0;
    localparam step_t S_DISP    = 4'd1;
    localparam step_t S_ADD     = 4'd2;
    localparam step_t S_ELSTART = 4'd3;
    localparam step_t S_RD      = 4'd4;
    localparam step_t S_EVAL    = 4'd5;
    localparam step_t S_WAKE    = 4'd6;
    localparam step_t S_LOOP    = 4'd7;
    localparam step_t S_FINAL   = 4'd8;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_ACCEPT,
        ACT_ADD,
        ACT_EL_INIT,
        ACT_READ,
        ACT_EVAL,
        ACT_EMIT_WAKE,
        ACT_EMIT_FINAL
    } act_t;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_IN_VALID,
        C_OP_ADD,
        C_CNT_ZERO,
        C_EXP_WAKE,
        C_OUT_FREE,
        C_LEFT_ZERO
    } cond_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        step_t tgt_true;
        step_t tgt_false;
    } uword_t;

    typedef struct packed {
        logic [DUR_W-1:0]  rem;
        logic              wake;
        logic [TASK_W-1:0] task_id;
    } entry_t;

    function automatic uword_t ucode_rom(input step_t s);
        uword_t w;
        unique case (s)
            S_IDLE:    w = '{ACT_ACCEPT,     C_IN_VALID,  S_DISP,  S_IDLE};
            S_DISP:    w = '{ACT_NONE,       C_OP_ADD,    S_ADD,   S_ELSTART};
            S_ADD:     w = '{ACT_ADD,        C_ALWAYS,    S_FINAL, S_FINAL};
            S_ELSTART: w = '{ACT_EL_INIT,    C_CNT_ZERO,  S_FINAL, S_RD};
            S_RD:      w = '{ACT_READ,       C_ALWAYS,    S_EVAL,  S_EVAL};
            S_EVAL:    w = '{ACT_EVAL,       C_EXP_WAKE,  S_WAKE,  S_LOOP};
            S_WAKE:    w = '{ACT_EMIT_WAKE,  C_OUT_FREE,  S_LOOP,  S_WAKE};
            S_LOOP:    w = '{ACT_NONE,       C_LEFT_ZERO, S_FINAL, S_RD};
            S_FINAL:   w = '{ACT_EMIT_FINAL, C_OUT_FREE,  S_IDLE,  S_FINAL};
            default:   w = '{ACT_NONE,       C_ALWAYS,    S_IDLE,  S_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/stt_if.sv
// valid/ready channel interfaces for timer requests and results
`default_nettype none

interface stt_in_if import stt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              operation;
    logic [DUR_W-1:0]  duration_ms;
    logic [TASK_W-1:0] task_id;
    logic              wake_on_expiry;

    modport source (output valid, operation, duration_ms, task_id, wake_on_expiry,
                    input ready);
    modport sink   (input valid, operation, duration_ms, task_id, wake_on_expiry,
                    output ready);
endinterface

interface stt_out_if import stt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              wake_valid;
    logic [TASK_W-1:0] wake_task;
    logic [DUR_W-1:0]  next_period_ms;
    logic [UP_W-1:0]   uptime_ms;
    logic              table_full;
    logic              last;

    modport source (output valid, wake_valid, wake_task, next_period_ms, uptime_ms,
                    table_full, last, input ready);
    modport sink   (input valid, wake_valid, wake_task, next_period_ms, uptime_ms,
                    table_full, last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/sleep_timer_table_top.sv
// sleep timer table: microcoded sequencer over a circular entry memory
//
//   channel   dir   handshake     word
//   in_ch     in    valid/ready   operation, duration_ms, task_id, wake_on_expiry
//   out_ch    out   valid/ready   wake_valid, wake_task, next_period_ms, uptime_ms,
//                                 table_full, last
//   cfg       in    cfg_we        cfg_wdata -> max_timer_period
//
// add: the program steps through accept, dispatch and add, then emits the final word.
// elapse: the entry memory has one read and one write port, and after an init step each
// live entry takes a read, an evaluate and a loop step, plus a wake step when it wakes.
// reset clears the count, uptime and sequencer; the memory is not cleared.
// an output stall holds the sequencer in its emit step until the previous word is taken.
`default_nettype none
`include "assert_macros.svh"

module sleep_timer_table_top import stt_pkg::*; #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [DUR_W-1:0] cfg_wdata,
    stt_in_if.sink                in_ch,
    stt_out_if.source             out_ch
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // base + count (minus one), wrapped into the circular table
    function automatic idx_t wrap_sum(input idx_t b, input cnt_t c, input logic minus_one);
        logic [SUM_W-1:0] s;
        s = SUM_W'(b) + SUM_W'(c) - SUM_W'(minus_one);
        if (s >= SUM_W'(TABLE_DEPTH))
            s = s - SUM_W'(TABLE_DEPTH);
        return s[IDX_W-1:0];
    endfunction

    function automatic idx_t wrap_dec(input idx_t i);
        return (i == '0) ? IDX_W'(TABLE_DEPTH - 1) : i - 1'b1;
    endfunction

    // sequencer and control
    step_t             step_reg;
    logic [DUR_W-1:0]  cap_reg;
    cnt_t              count_reg;
    cnt_t              left_reg;
    idx_t              base_reg;
    idx_t              rd_ptr_reg;
    idx_t              wr_ptr_reg;
    logic [DUR_W-1:0]  min_reg;
    logic [UP_W-1:0]   uptime_reg;
    logic              full_reg;
    logic              out_valid_reg;

    // latched request and memory read data
    logic              op_reg;
    logic [DUR_W-1:0]  dur_reg;
    logic [TASK_W-1:0] task_reg;
    logic              wake_in_reg;
    entry_t            rd_data_reg;

    // output word
    logic              o_wake_reg;
    logic [TASK_W-1:0] o_task_reg;
    logic [DUR_W-1:0]  o_period_reg;
    logic [UP_W-1:0]   o_uptime_reg;
    logic              o_full_reg;
    logic              o_last_reg;

    entry_t            mem [TABLE_DEPTH];

    uword_t            uw;
    step_t             step_next;
    logic              cond_true;
    logic              accept;
    logic              out_free;
    logic              expired;
    logic              is_full;
    idx_t              add_idx;
    idx_t              top_idx;
    logic [DUR_W-1:0]  survive_rem;
    logic [DUR_W-1:0]  next_period;
    logic              mem_we;
    idx_t              mem_waddr;
    entry_t            mem_wdata;

    assign uw          = ucode_rom(step_reg);
    assign in_ch.ready = (uw.act == ACT_ACCEPT);
    assign accept      = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign expired     = (rd_data_reg.rem <= dur_reg);
    assign is_full     = (count_reg == CNT_W'(TABLE_DEPTH));
    assign add_idx     = wrap_sum(base_reg, count_reg, 1'b0);
    assign top_idx     = wrap_sum(base_reg, count_reg, 1'b1);
    assign survive_rem = rd_data_reg.rem - dur_reg;
    assign next_period = (count_reg == '0) ? cap_reg :
                         ((min_reg < cap_reg) ? min_reg : cap_reg);

    always_comb
    begin
        unique case (uw.cond)
            C_ALWAYS:    cond_true = 1'b1;
            C_IN_VALID:  cond_true = in_ch.valid;
            C_OP_ADD:    cond_true = (op_reg == OP_ADD);
            C_CNT_ZERO:  cond_true = (count_reg == '0);
            C_EXP_WAKE:  cond_true = expired && rd_data_reg.wake;
            C_OUT_FREE:  cond_true = out_free;
            C_LEFT_ZERO: cond_true = (left_reg == '0);
            default:     cond_true = 1'b0;
        endcase
        step_next = cond_true ? uw.tgt_true : uw.tgt_false;
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = add_idx;
        mem_wdata = '{rem: dur_reg, wake: wake_in_reg, task_id: task_reg};
        if (uw.act == ACT_ADD)
        begin
            mem_we = !is_full;
        end
        else if (uw.act == ACT_EVAL)
        begin
            // survivors are packed downward from the old top entry
            mem_we    = !expired;
            mem_waddr = wr_ptr_reg;
            mem_wdata = '{rem: survive_rem, wake: rd_data_reg.wake,
                          task_id: rd_data_reg.task_id};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (uw.act == ACT_READ)
            rd_data_reg <= mem[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= S_IDLE;
            cap_reg       <= CAP_RESET;
            count_reg     <= '0;
            left_reg      <= '0;
            base_reg      <= '0;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            min_reg       <= '1;
            uptime_reg    <= '0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_wdata;
            step_reg <= step_next;
            if ((uw.act == ACT_EMIT_WAKE || uw.act == ACT_EMIT_FINAL) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
            unique case (uw.act)
                ACT_ADD:
                begin
                    full_reg <= is_full;
                    if (!is_full)
                    begin
                        count_reg <= count_reg + 1'b1;
                        if (count_reg == '0 || dur_reg < min_reg)
                            min_reg <= dur_reg;
                    end
                end
                ACT_EL_INIT:
                begin
                    uptime_reg <= uptime_reg + UP_W'(dur_reg);
                    count_reg  <= '0;
                    left_reg   <= count_reg;
                    rd_ptr_reg <= top_idx;
                    wr_ptr_reg <= top_idx;
                    min_reg    <= '1;
                    full_reg   <= 1'b0;
                end
                ACT_EVAL:
                begin
                    left_reg   <= left_reg - 1'b1;
                    rd_ptr_reg <= wrap_dec(rd_ptr_reg);
                    if (!expired)
                    begin
                        wr_ptr_reg <= wrap_dec(wr_ptr_reg);
                        base_reg   <= wr_ptr_reg;
                        count_reg  <= count_reg + 1'b1;
                        if (survive_rem < min_reg)
                            min_reg <= survive_rem;
                    end
                end
                ACT_NONE, ACT_ACCEPT, ACT_READ, ACT_EMIT_WAKE, ACT_EMIT_FINAL:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= in_ch.operation;
            dur_reg     <= in_ch.duration_ms;
            task_reg    <= in_ch.task_id;
            wake_in_reg <= in_ch.wake_on_expiry;
        end
        if (uw.act == ACT_EMIT_WAKE && out_free)
        begin
            o_wake_reg   <= 1'b1;
            o_task_reg   <= rd_data_reg.task_id;
            o_period_reg <= '0;
            o_uptime_reg <= uptime_reg;
            o_full_reg   <= 1'b0;
            o_last_reg   <= 1'b0;
        end
        else if (uw.act == ACT_EMIT_FINAL && out_free)
        begin
            o_wake_reg   <= 1'b0;
            o_task_reg   <= '0;
            o_period_reg <= next_period;
            o_uptime_reg <= uptime_reg;
            o_full_reg   <= full_reg;
            o_last_reg   <= 1'b1;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.wake_valid     = o_wake_reg;
    assign out_ch.wake_task      = o_task_reg;
    assign out_ch.next_period_ms = o_period_reg;
    assign out_ch.uptime_ms      = o_uptime_reg;
    assign out_ch.table_full     = o_full_reg;
    assign out_ch.last           = o_last_reg;

    `STT_ASSERT_NEXT(a_accept_dispatch, clk, rst_n, accept, step_reg == S_DISP)
    `STT_ASSERT_IMP(a_wake_word_shape, clk, rst_n, out_valid_reg && o_wake_reg,
        o_period_reg == '0 && !o_last_reg && !o_full_reg)
    `STT_ASSERT_NEXT(a_full_add_keeps, clk, rst_n, uw.act == ACT_ADD && is_full,
        count_reg == CNT_W'(TABLE_DEPTH) && full_reg)
    `STT_ASSERT_IMP(a_eval_has_entry, clk, rst_n, uw.act == ACT_EVAL, left_reg != '0)

endmodule

`default_nettype wire

>>> bench/sleep_timer_table_top_tb.sv
// self-checking testbench for the sleep timer table: directed timer cases, then random traffic
`default_nettype none

module sleep_timer_table_top_tb import stt_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 16;

    typedef struct {
        logic              wake_valid;
        logic [TASK_W-1:0] wake_task;
        logic [DUR_W-1:0]  next_period_ms;
        logic [UP_W-1:0]   uptime_ms;
        logic              table_full;
        logic              last;
    } timer_word_t;

    typedef enum {RX_OPEN, RX_RANDOM, RX_RUNS} rx_mode_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [DUR_W-1:0] cfg_wdata;

    stt_in_if  in_ch();
    stt_out_if out_ch();

    sleep_timer_table_top #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // predicted timer table
    logic [DUR_W-1:0]  tbl_rem [TABLE_DEPTH];
    logic              tbl_wake [TABLE_DEPTH];
    logic [TASK_W-1:0] tbl_owner [TABLE_DEPTH];
    int                tbl_count;
    logic [UP_W-1:0]   uptime_acc;
    logic [DUR_W-1:0]  period_cap;

    timer_word_t pending_words[$];
    int          mismatch_count;

    rx_mode_t rx_mode;
    bit       tx_gaps;
    int       tx_burst_left;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic logic [DUR_W-1:0] next_timer_period();
        logic [DUR_W-1:0] best;
        best = period_cap;
        for (int i = 0; i < tbl_count; i++)
        begin
            if (tbl_rem[i] < best)
                best = tbl_rem[i];
        end
        return best;
    endfunction

    task automatic push_timer_word(input logic wv, input logic [TASK_W-1:0] tid,
                                   input logic [DUR_W-1:0] period, input logic full,
                                   input logic fin);
        timer_word_t w;
        w.wake_valid     = wv;
        w.wake_task      = tid;
        w.next_period_ms = period;
        w.uptime_ms      = uptime_acc;
        w.table_full     = full;
        w.last           = fin;
        pending_words.push_back(w);
    endtask

    task automatic predict_timer_item(input logic op, input logic [DUR_W-1:0] dur,
                                      input logic [TASK_W-1:0] tid, input logic wk);
        logic full;
        if (op == OP_ADD)
        begin
            full = (tbl_count >= TABLE_DEPTH);
            if (!full)
            begin
                tbl_rem[tbl_count]   = dur;
                tbl_wake[tbl_count]  = wk;
                tbl_owner[tbl_count] = tid;
                tbl_count++;
            end
            push_timer_word(1'b0, '0, next_timer_period(), full, 1'b1);
        end
        else
        begin
            uptime_acc = uptime_acc + {32'd0, dur};
            // walk newest to oldest, closing the gap behind each expired entry
            for (int i = tbl_count - 1; i >= 0; i--)
            begin
                if (tbl_rem[i] <= dur)
                begin
                    if (tbl_wake[i])
                        push_timer_word(1'b1, tbl_owner[i], '0, 1'b0, 1'b0);
                    for (int j = i; j + 1 < tbl_count; j++)
                    begin
                        tbl_rem[j]   = tbl_rem[j + 1];
                        tbl_wake[j]  = tbl_wake[j + 1];
                        tbl_owner[j] = tbl_owner[j + 1];
                    end
                    tbl_count--;
                end
                else
                begin
                    tbl_rem[i] = tbl_rem[i] - dur;
                end
            end
            push_timer_word(1'b0, '0, next_timer_period(), 1'b0, 1'b1);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            predict_timer_item(in_ch.operation, in_ch.duration_ms, in_ch.task_id,
                               in_ch.wake_on_expiry);
    end

    always @(posedge clk)
    begin
        timer_word_t w;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_words.size() == 0)
            begin
                report_mismatch("unexpected word, last flag", 64'(out_ch.last), 64'd0);
            end
            else
            begin
                w = pending_words.pop_front();
                if (out_ch.wake_valid !== w.wake_valid)
                    report_mismatch("wake_valid", 64'(out_ch.wake_valid),
                                    64'(w.wake_valid));
                if (out_ch.wake_task !== w.wake_task)
                    report_mismatch("wake_task", 64'(out_ch.wake_task), 64'(w.wake_task));
                if (out_ch.next_period_ms !== w.next_period_ms)
                    report_mismatch("next_period_ms", 64'(out_ch.next_period_ms),
                                    64'(w.next_period_ms));
                if (out_ch.uptime_ms !== w.uptime_ms)
                    report_mismatch("uptime_ms", out_ch.uptime_ms, w.uptime_ms);
                if (out_ch.table_full !== w.table_full)
                    report_mismatch("table_full", 64'(out_ch.table_full),
                                    64'(w.table_full));
                if (out_ch.last !== w.last)
                    report_mismatch("last", 64'(out_ch.last), 64'(w.last));
            end
        end
    end

    // result side back-pressure
    initial
    begin : receiver
        int run_left;
        run_left = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            case (rx_mode)
                RX_OPEN:   out_ch.ready = 1'b1;
                RX_RANDOM: out_ch.ready = ($urandom_range(0, 3) != 0);
                default:
                begin
                    if (run_left == 0)
                    begin
                        out_ch.ready = !out_ch.ready;
                        run_left = out_ch.ready ? $urandom_range(1, 8) : $urandom_range(1, 20);
                    end
                    run_left--;
                end
            endcase
        end
    end

    // valid is left high after acceptance; the next call or a drain replaces it
    task automatic send_timer_item(input logic op, input logic [DUR_W-1:0] dur,
                                   input logic [TASK_W-1:0] tid, input logic wk);
        @(negedge clk);
        if (tx_gaps && tx_burst_left <= 0)
        begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            tx_burst_left = $urandom_range(1, 16);
        end
        in_ch.valid          = 1'b1;
        in_ch.operation      = op;
        in_ch.duration_ms    = dur;
        in_ch.task_id        = tid;
        in_ch.wake_on_expiry = wk;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        tx_burst_left--;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (pending_words.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_period_cap(input logic [DUR_W-1:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we     = 1'b0;
        period_cap = value;
    endtask

    task automatic test_empty_table();
        rx_mode = RX_OPEN;
        tx_gaps = 1'b0;
        send_timer_item(OP_ELAPSE, 32'd0, 16'h0000, 1'b0);
        wait_drained();
    endtask

    task automatic test_special_durations();
        rx_mode = RX_RANDOM;
        send_timer_item(OP_ADD, 32'd0, 16'h0001, 1'b1);
        send_timer_item(OP_ADD, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        send_timer_item(OP_ADD, 32'd1, 16'h0000, 1'b0);
        // zero elapse still expires the zero-duration entry
        send_timer_item(OP_ELAPSE, 32'd0, 16'h5A5A, 1'b1);
        send_timer_item(OP_ELAPSE, 32'd1, 16'hA5A5, 1'b0);
        send_timer_item(OP_ELAPSE, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        wait_drained();
    endtask

    task automatic test_full_table();
        rx_mode = RX_RUNS;
        tx_gaps = 1'b1;
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_timer_item(OP_ADD, 32'(3 * i + 2), 16'hA500 | 16'(i), 1'b1);
        send_timer_item(OP_ADD, 32'd7, 16'hBEEF, 1'b1);
        // every entry wakes: the largest word count one item can give
        send_timer_item(OP_ELAPSE, 32'hFFFF_FFFF, 16'h0000, 1'b0);
        wait_drained();
    endtask

    task automatic test_random_phases();
        logic [DUR_W-1:0] caps [6];
        logic             op;
        logic [DUR_W-1:0] dur;
        int               add_pct;
        int               pick;
        caps[0] = 32'd0;
        caps[1] = 32'hFFFF_FFFF;
        caps[2] = 32'd1;
        caps[3] = $urandom_range(2, 60);
        caps[4] = $urandom;
        caps[5] = CAP_RESET;
        for (int ph = 0; ph < 6; ph++)
        begin
            wait_drained();
            write_period_cap(caps[ph]);
            rx_mode = rx_mode_t'(ph % 3);
            tx_gaps = (ph != 0);
            add_pct = $urandom_range(55, 90);
            for (int n = 0; n < 80; n++)
            begin
                if (n == 40)
                    wait_drained();
                op   = ($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_ELAPSE;
                pick = $urandom_range(0, 15);
                if (op == OP_ADD)
                    dur = (pick == 0) ? $urandom : (pick == 1) ? 32'd0 : $urandom_range(1, 48);
                else
                    dur = (pick == 0) ? $urandom : (pick < 3) ? 32'd0 : $urandom_range(1, 16);
                send_timer_item(op, dur, 16'($urandom), 1'($urandom));
            end
        end
    endtask

    initial
    begin
        int spin;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = '0;
        in_ch.valid          = 1'b0;
        in_ch.operation      = OP_ADD;
        in_ch.duration_ms    = '0;
        in_ch.task_id        = '0;
        in_ch.wake_on_expiry = 1'b0;
        rx_mode              = RX_OPEN;
        tx_gaps              = 1'b0;
        tx_burst_left        = 0;
        tbl_count            = 0;
        uptime_acc           = '0;
        period_cap           = CAP_RESET;
        mismatch_count       = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_special_durations();
        test_full_table();
        test_random_phases();

        @(negedge clk);
        in_ch.valid = 1'b0;
        spin = 0;
        while (pending_words.size() != 0 && spin < 20000)
        begin
            @(negedge clk);
            spin++;
        end
        repeat (80) @(negedge clk);
        if (pending_words.size() != 0)
            report_mismatch("words never produced", 64'(pending_words.size()), 64'd0);

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
